[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the jump stepper; compiled out when
// NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define MJGS_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define MJGS_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define MJGS_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define MJGS_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

[src/mjgs_pkg.sv]
// ----------------------------------------------------------------------------
// Jump stepper package
// Types, codes, field layout and fixed constants of the jump stepper.
// ----------------------------------------------------------------------------
package mjgs_pkg;

   localparam int RATE_W       = 24;
   localparam int TIME_W       = 32;
   localparam int COUNT_W      = 16;
   localparam int EXP_W        = 32;
   localparam int UNIF_W       = 32;
   localparam int IDX_FIELD_W  = 2;
   localparam int EXP_SHIFT    = 8;
   localparam int DIVIDEND_W   = EXP_W + EXP_SHIFT;

   localparam int REQ_TUSER_W  = 2;
   localparam int REQ_TDATA_W  = 96;
   localparam int RSP_TUSER_W  = 3;
   localparam int RSP_TDATA_W  = 56;
   localparam int RSP_PAD_W    = RSP_TDATA_W - TIME_W - IDX_FIELD_W - COUNT_W;

   localparam int FROM_LSB     = 0;
   localparam int TO_LSB       = FROM_LSB + IDX_FIELD_W;
   localparam int RATE_LSB     = TO_LSB + IDX_FIELD_W;
   localparam int START_LSB    = RATE_LSB + RATE_W;
   localparam int EXP_LSB      = START_LSB + IDX_FIELD_W;
   localparam int UNIF_LSB     = EXP_LSB + EXP_W;

   localparam int CSR_INDEX_W  = 4;
   localparam int CSR_DATA_W   = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_TIME_LIMIT = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_STEP_LIMIT = 4'd1;

   localparam logic [TIME_W-1:0]  TIME_LIMIT_RESET = 32'd655360;
   localparam logic [COUNT_W-1:0] STEP_LIMIT_RESET = 16'd10000;
   localparam logic [TIME_W-1:0]  TIME_MAX         = 32'hFFFF_FFFF;
   localparam logic [COUNT_W-1:0] COUNT_MAX        = 16'hFFFF;

   typedef enum logic [1:0] {
      REQ_WRITE = 2'd0,
      REQ_START = 2'd1,
      REQ_JUMP  = 2'd2
   } req_kind_type;

   typedef enum logic [2:0] {
      ST_WRITTEN = 3'd0,
      ST_IGNORED = 3'd1,
      ST_STARTED = 3'd2,
      ST_JUMPED  = 3'd3,
      ST_TRAPPED = 3'd4,
      ST_TLIMIT  = 3'd5,
      ST_SLIMIT  = 3'd6,
      ST_IDLE    = 3'd7
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SUM,
      S_DIV,
      S_PICK,
      S_DONE
   } state_type;

endpackage

[src/mjgs_rate_mem.sv]
// ----------------------------------------------------------------------------
// Rate table memory
// One write port, one read port with registered data; entries never written
// since reset read as zero.
// ----------------------------------------------------------------------------
module mjgs_rate_mem #(
   parameter int ADDR_W = 4
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        wr_en,
   input  logic [ADDR_W-1:0]           wr_addr,
   input  logic [mjgs_pkg::RATE_W-1:0] wr_data,
   input  logic                        rd_en,
   input  logic [ADDR_W-1:0]           rd_addr,
   output logic [mjgs_pkg::RATE_W-1:0] rd_data
);
   import mjgs_pkg::*;

   localparam int DEPTH = 1 << ADDR_W;

   logic [RATE_W-1:0] mem [DEPTH];
   logic [DEPTH-1:0]  vld_ff;
   logic [RATE_W-1:0] rd_raw_ff;
   logic              rd_vld_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_raw_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_vld_ff <= vld_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_vld_ff ? rd_raw_ff : '0;

endmodule

[src/mjgs_div.sv]
// ----------------------------------------------------------------------------
// Holding time divider
// Restoring division, one quotient bit per cycle, done pulses after the
// last bit.
// ----------------------------------------------------------------------------
module mjgs_div #(
   parameter int DIVISOR_W = 26
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [mjgs_pkg::DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]            divisor,
   output logic                            done,
   output logic [mjgs_pkg::DIVIDEND_W-1:0] quotient
);
   import mjgs_pkg::*;

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  dvs_ff, dvs_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W:0]    rem_sh;
   logic [DIVISOR_W:0]    rem_diff;
   logic                  ge;

   always_comb begin
      rem_sh   = {rem_ff, quo_ff[DIVIDEND_W-1]};
      ge       = rem_sh >= {1'b0, dvs_ff};
      rem_diff = rem_sh - {1'b0, dvs_ff};
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      rem_in   = rem_ff;
      dvs_in   = dvs_ff;
      quo_in   = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DIVIDEND_W);
         rem_in  = '0;
         dvs_in  = divisor;
         quo_in  = dividend;
      end else if (busy_ff) begin
         rem_in = ge ? rem_diff[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
         quo_in = {quo_ff[DIVIDEND_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

[src/markov_jump_gillespie_step_core.sv]
// ----------------------------------------------------------------------------
// Markov jump stepper core
// Direct-method stochastic stepper: rate table in memory, row sum, iterative
// holding time division and cumulative destination pick.
// ----------------------------------------------------------------------------
//  channel | direction | accepted when          | carries
//  req_    | in        | req_tvalid & req_tready | rate write, start, jump
//  rsp_    | out       | rsp_tvalid & rsp_tready | status, time, state, count
//  csr_    | in        | csr_valid & csr_ready   | time_limit, step_limit
//
// Write, start and idle items go from idle to the done state and back; a
// jump that runs to the pick scans its row through the one read port of the
// rate memory to sum it, runs the bit-serial divider, scans the row again to
// pick the destination, then loads the result and returns to idle.
// Reset is synchronous; the rate table reads as zero after reset, no sweep.
// A new item is taken while the previous result waits in the output register;
// only the final result load waits on rsp_tready.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module markov_jump_gillespie_step_core #(
   parameter int NUM_STATES = 4
) (
   input  logic                             clock,
   input  logic                             reset,
   // tuser: req_type[1:0]
   input  logic [mjgs_pkg::REQ_TUSER_W-1:0] req_tuser,
   // tdata: src_state[1:0], dst_state[3:2], rate_value[27:4],
   //        start_state[29:28], exp_sample[61:30], uniform_pick[93:62]
   input  logic [mjgs_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // tuser: status[2:0]
   output logic [mjgs_pkg::RSP_TUSER_W-1:0] rsp_tuser,
   // tdata: sim_time[31:0], sim_state[33:32], jump_count[49:34]
   output logic [mjgs_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [mjgs_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [mjgs_pkg::CSR_DATA_W-1:0]  csr_data
);
   import mjgs_pkg::*;

   localparam int SW     = $clog2(NUM_STATES);
   localparam int IXW    = $clog2(NUM_STATES + 1);
   localparam int EW     = SW + IDX_FIELD_W;
   localparam int AW     = 2 * SW;
   localparam int LW     = RATE_W + SW;
   localparam int PROD_W = UNIF_W + LW;

   state_type             state_ff, state_in;
   status_type            res_status_ff, res_status_in;
   logic [SW-1:0]         row_ff, row_in;
   logic [TIME_W-1:0]     time_ff, time_in;
   logic [COUNT_W-1:0]    steps_ff, steps_in;
   logic                  active_ff, active_in;
   logic [TIME_W-1:0]     tlim_ff;
   logic [COUNT_W-1:0]    slim_ff;
   logic [EXP_W-1:0]      exp_ff, exp_in;
   logic [UNIF_W-1:0]     unif_ff, unif_in;
   logic [IXW-1:0]        idx_ff, idx_in;
   logic                  rd_vld_ff, rd_vld_in;
   logic [SW-1:0]         rd_col_ff, rd_col_in;
   logic [LW-1:0]         lambda_ff, lambda_in;
   logic [LW-1:0]         prod_hi_ff, prod_hi_in;
   logic [LW-1:0]         cum_ff, cum_in;
   logic [SW-1:0]         pick_ff, pick_in;
   logic [TIME_W-1:0]     new_time_ff, new_time_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [RSP_TUSER_W-1:0] rsp_user_ff, rsp_user_in;

   logic [EW-1:0]         from_w, to_w, start_w, start_sel, row_out_w;
   logic                  wr_ok;
   logic                  mem_wr_en, mem_rd_en;
   logic [AW-1:0]         mem_wr_addr, mem_rd_addr;
   logic [RATE_W-1:0]     rd_data;
   logic                  div_start, div_done;
   logic [DIVIDEND_W-1:0] div_quo;
   logic [TIME_W-1:0]     tau_sat, time_new;
   logic [TIME_W:0]       time_sum;
   logic [PROD_W-1:0]     prod_w;
   logic [LW-1:0]         cum_sum;
   logic                  issue, col_use, hit, commit;
   logic [COUNT_W-1:0]    steps_inc, out_count;
   logic [TIME_W-1:0]     out_time;
   logic [SW-1:0]         out_row;

   assign from_w    = {{SW{1'b0}}, req_tdata[FROM_LSB +: IDX_FIELD_W]};
   assign to_w      = {{SW{1'b0}}, req_tdata[TO_LSB +: IDX_FIELD_W]};
   assign start_w   = {{SW{1'b0}}, req_tdata[START_LSB +: IDX_FIELD_W]};
   assign wr_ok     = (from_w != to_w) && (from_w < EW'(NUM_STATES)) &&
                      (to_w < EW'(NUM_STATES));
   assign start_sel = (start_w < EW'(NUM_STATES)) ? start_w : EW'(NUM_STATES - 1);

   assign mem_wr_en   = req_tvalid && req_tready && (req_tuser == REQ_WRITE) && wr_ok;
   assign mem_wr_addr = {from_w[SW-1:0], to_w[SW-1:0]};
   assign mem_rd_addr = {row_ff, idx_ff[SW-1:0]};

   mjgs_rate_mem #(
      .ADDR_W (AW)
   ) u_rate_mem (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (req_tdata[RATE_LSB +: RATE_W]),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (rd_data)
   );

   mjgs_div #(
      .DIVISOR_W (LW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({exp_ff, {EXP_SHIFT{1'b0}}}),
      .divisor  (lambda_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign tau_sat  = (div_quo[DIVIDEND_W-1:TIME_W] != '0) ? TIME_MAX :
                     div_quo[TIME_W-1:0];
   assign time_sum = {1'b0, time_ff} + {1'b0, tau_sat};
   assign time_new = time_sum[TIME_W] ? TIME_MAX : time_sum[TIME_W-1:0];
   assign prod_w   = PROD_W'(unif_ff) * PROD_W'(lambda_ff);
   assign prod_hi_in = prod_w[PROD_W-1:UNIF_W];
   assign cum_sum  = cum_ff + LW'(rd_data);
   assign col_use  = rd_vld_ff && (rd_col_ff != row_ff);
   assign hit      = (state_ff == S_PICK) && col_use && (prod_hi_ff < cum_sum);
   assign commit   = !rsp_valid_ff || rsp_tready;
   assign steps_inc = (steps_ff != COUNT_MAX) ? steps_ff + 1'b1 : steps_ff;

   always_comb begin
      out_row   = row_ff;
      out_time  = time_ff;
      out_count = steps_ff;
      case (res_status_ff)
         ST_STARTED: begin
            out_row   = pick_ff;
            out_time  = '0;
            out_count = '0;
         end
         ST_JUMPED: begin
            out_row   = pick_ff;
            out_time  = new_time_ff;
            out_count = steps_inc;
         end
         default: begin
         end
      endcase
   end

   assign row_out_w = {{IDX_FIELD_W{1'b0}}, out_row};

   always_comb begin
      state_in      = state_ff;
      res_status_in = res_status_ff;
      row_in        = row_ff;
      time_in       = time_ff;
      steps_in      = steps_ff;
      active_in     = active_ff;
      exp_in        = exp_ff;
      unif_in       = unif_ff;
      idx_in        = idx_ff;
      rd_vld_in     = 1'b0;
      rd_col_in     = idx_ff[SW-1:0];
      lambda_in     = lambda_ff;
      cum_in        = cum_ff;
      pick_in       = pick_ff;
      new_time_in   = new_time_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_user_in   = rsp_user_ff;
      mem_rd_en     = 1'b0;
      div_start     = 1'b0;
      issue         = 1'b0;
      req_tready    = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               exp_in   = req_tdata[EXP_LSB +: EXP_W];
               unif_in  = req_tdata[UNIF_LSB +: UNIF_W];
               state_in = S_DONE;
               case (req_tuser)
                  REQ_WRITE: begin
                     res_status_in = wr_ok ? ST_WRITTEN : ST_IGNORED;
                  end
                  REQ_START: begin
                     pick_in       = start_sel[SW-1:0];
                     res_status_in = ST_STARTED;
                  end
                  REQ_JUMP: begin
                     if (!active_ff) begin
                        res_status_in = ST_IDLE;
                     end else if (steps_ff >= slim_ff) begin
                        res_status_in = ST_SLIMIT;
                     end else if (time_ff >= tlim_ff) begin
                        res_status_in = ST_TLIMIT;
                     end else begin
                        idx_in    = '0;
                        lambda_in = '0;
                        state_in  = S_SUM;
                     end
                  end
                  default: begin
                     res_status_in = ST_IDLE;
                  end
               endcase
            end
         end
         S_SUM: begin
            issue     = idx_ff != IXW'(NUM_STATES);
            mem_rd_en = issue;
            rd_vld_in = issue;
            if (issue) begin
               idx_in = idx_ff + 1'b1;
            end
            if (col_use) begin
               lambda_in = lambda_ff + LW'(rd_data);
            end
            if (!issue && !rd_vld_ff) begin
               if (lambda_ff == '0) begin
                  res_status_in = ST_TRAPPED;
                  state_in      = S_DONE;
               end else begin
                  div_start = 1'b1;
                  state_in  = S_DIV;
               end
            end
         end
         S_DIV: begin
            if (div_done) begin
               if (time_new >= tlim_ff) begin
                  res_status_in = ST_TLIMIT;
                  state_in      = S_DONE;
               end else begin
                  new_time_in = time_new;
                  idx_in      = '0;
                  cum_in      = '0;
                  state_in    = S_PICK;
               end
            end
         end
         S_PICK: begin
            issue     = (idx_ff != IXW'(NUM_STATES)) && !hit;
            mem_rd_en = issue;
            rd_vld_in = issue;
            if (issue) begin
               idx_in = idx_ff + 1'b1;
            end
            if (col_use) begin
               cum_in = cum_sum;
            end
            if (hit) begin
               pick_in       = rd_col_ff;
               res_status_in = ST_JUMPED;
               state_in      = S_DONE;
            end else if (!issue && !rd_vld_ff) begin
               pick_in       = row_ff;
               res_status_in = ST_JUMPED;
               state_in      = S_DONE;
            end
         end
         S_DONE: begin
            if (commit) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = res_status_ff;
               rsp_data_in  = {{RSP_PAD_W{1'b0}}, out_count,
                               row_out_w[IDX_FIELD_W-1:0], out_time};
               row_in       = out_row;
               time_in      = out_time;
               steps_in     = out_count;
               case (res_status_ff)
                  ST_STARTED: begin
                     active_in = 1'b1;
                  end
                  ST_TRAPPED, ST_TLIMIT, ST_SLIMIT: begin
                     active_in = 1'b0;
                  end
                  default: begin
                  end
               endcase
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         row_ff       <= '0;
         time_ff      <= '0;
         steps_ff     <= '0;
         active_ff    <= 1'b0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         time_ff      <= time_in;
         steps_ff     <= steps_in;
         active_ff    <= active_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_status_ff <= res_status_in;
      exp_ff        <= exp_in;
      unif_ff       <= unif_in;
      idx_ff        <= idx_in;
      rd_col_ff     <= rd_col_in;
      lambda_ff     <= lambda_in;
      prod_hi_ff    <= prod_hi_in;
      cum_ff        <= cum_in;
      pick_ff       <= pick_in;
      new_time_ff   <= new_time_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_user_ff   <= rsp_user_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tlim_ff <= TIME_LIMIT_RESET;
         slim_ff <= STEP_LIMIT_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_TIME_LIMIT: tlim_ff <= csr_data;
            CSR_STEP_LIMIT: slim_ff <= csr_data[COUNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   `MJGS_ASSERT_IMP(a_div_done_in_div, clock, reset, div_done, state_ff == S_DIV, "divider done outside divide phase")
   `MJGS_ASSERT_IMP(a_pick_below_lambda, clock, reset, state_ff == S_PICK, prod_hi_ff < lambda_ff, "pick target not below row sum")
   `MJGS_ASSERT_IMP(a_jump_has_rate, clock, reset, (state_ff == S_DONE) && (res_status_ff == ST_JUMPED), lambda_ff != '0, "jump with zero row sum")
   `MJGS_ASSERT_NXT(a_stop_clears_run, clock, reset, (state_ff == S_DONE) && commit && ((res_status_ff == ST_TRAPPED) || (res_status_ff == ST_TLIMIT) || (res_status_ff == ST_SLIMIT)), !active_ff, "run still active after stop")

endmodule

[verif/markov_jump_gillespie_step_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Jump stepper scoreboard
// Watches the request, result and register channels of the jump stepper,
// keeps its own copy of the rate table, chain state and limits, predicts one
// result per accepted item and compares every accepted result field by field.
// ----------------------------------------------------------------------------
module mjgs_chain_checker #(
   parameter int NUM_STATES = 4
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [mjgs_pkg::REQ_TUSER_W-1:0] req_tuser,
   input  logic [mjgs_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic [mjgs_pkg::RSP_TUSER_W-1:0] rsp_tuser,
   input  logic [mjgs_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic                             csr_valid,
   input  logic                             csr_ready,
   input  logic [mjgs_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [mjgs_pkg::CSR_DATA_W-1:0]  csr_data,
   output int                               fail_count,
   output int                               pending,
   output int                               results_checked,
   output int                               jumps_seen,
   output int                               ends_seen
);
   import mjgs_pkg::*;

   typedef struct packed {
      status_type             status;
      logic [TIME_W-1:0]      sim_time;
      logic [IDX_FIELD_W-1:0] sim_state;
      logic [COUNT_W-1:0]     jump_count;
   } chain_point_type;

   logic [RATE_W-1:0]      rate_mem [NUM_STATES][NUM_STATES];
   logic [IDX_FIELD_W-1:0] chain_state;
   logic [TIME_W-1:0]      chain_time;
   logic [COUNT_W-1:0]     chain_jumps;
   logic                   chain_running;
   logic [TIME_W-1:0]      cfg_time_limit;
   logic [COUNT_W-1:0]     cfg_step_limit;

   chain_point_type expected_points [$];
   int mismatch_total = 0;
   int checked_total  = 0;
   int jump_total     = 0;
   int end_total      = 0;

   function automatic chain_point_type advance_chain(input logic [REQ_TUSER_W-1:0] kind,
                                                     input logic [REQ_TDATA_W-1:0] d);
      logic [IDX_FIELD_W-1:0] src, dst, start_idx, next;
      logic [RATE_W-1:0]      rate;
      logic [63:0]            expv, unif, lambda, tau, t_next, target, cum;
      logic                   hit;
      status_type             st;
      chain_point_type        r;
      src       = d[FROM_LSB +: IDX_FIELD_W];
      dst       = d[TO_LSB +: IDX_FIELD_W];
      rate      = d[RATE_LSB +: RATE_W];
      start_idx = d[START_LSB +: IDX_FIELD_W];
      expv      = 64'(d[EXP_LSB +: EXP_W]);
      unif      = 64'(d[UNIF_LSB +: UNIF_W]);
      case (kind)
         REQ_WRITE: begin
            if (src != dst && src < NUM_STATES && dst < NUM_STATES) begin
               rate_mem[src][dst] = rate;
               st = ST_WRITTEN;
            end else begin
               st = ST_IGNORED;
            end
         end
         REQ_START: begin
            chain_state   = (start_idx < NUM_STATES) ? start_idx :
                            IDX_FIELD_W'(NUM_STATES - 1);
            chain_time    = '0;
            chain_jumps   = '0;
            chain_running = 1'b1;
            st = ST_STARTED;
         end
         REQ_JUMP: begin
            if (!chain_running) begin
               st = ST_IDLE;
            end else if (chain_jumps >= cfg_step_limit) begin
               chain_running = 1'b0;
               st = ST_SLIMIT;
            end else if (chain_time >= cfg_time_limit) begin
               chain_running = 1'b0;
               st = ST_TLIMIT;
            end else begin
               lambda = '0;
               for (int j = 0; j < NUM_STATES; j++) begin
                  if (j != chain_state) lambda += 64'(rate_mem[chain_state][j]);
               end
               if (lambda == 0) begin
                  chain_running = 1'b0;
                  st = ST_TRAPPED;
               end else begin
                  tau = (expv << EXP_SHIFT) / lambda;
                  if (tau > 64'(TIME_MAX)) tau = 64'(TIME_MAX);
                  t_next = 64'(chain_time) + tau;
                  if (t_next > 64'(TIME_MAX)) t_next = 64'(TIME_MAX);
                  if (t_next >= 64'(cfg_time_limit)) begin
                     chain_running = 1'b0;
                     st = ST_TLIMIT;
                  end else begin
                     target = unif * lambda;
                     cum    = '0;
                     next   = chain_state;
                     hit    = 1'b0;
                     for (int j = 0; j < NUM_STATES; j++) begin
                        if (j != chain_state && !hit) begin
                           cum += 64'(rate_mem[chain_state][j]);
                           if (target < (cum << 32)) begin
                              next = IDX_FIELD_W'(j);
                              hit  = 1'b1;
                           end
                        end
                     end
                     chain_state = next;
                     chain_time  = t_next[TIME_W-1:0];
                     if (chain_jumps != COUNT_MAX) chain_jumps++;
                     st = ST_JUMPED;
                  end
               end
            end
         end
         default: st = ST_IDLE;
      endcase
      r.status     = st;
      r.sim_time   = chain_time;
      r.sim_state  = chain_state;
      r.jump_count = chain_jumps;
      return r;
   endfunction

   always @(posedge clock) begin
      chain_point_type        want;
      logic [RSP_TUSER_W-1:0] got_status;
      logic [TIME_W-1:0]      got_time;
      logic [IDX_FIELD_W-1:0] got_state;
      logic [COUNT_W-1:0]     got_count;
      if (reset) begin
         for (int i = 0; i < NUM_STATES; i++) begin
            for (int j = 0; j < NUM_STATES; j++) rate_mem[i][j] = '0;
         end
         chain_state    = '0;
         chain_time     = '0;
         chain_jumps    = '0;
         chain_running  = 1'b0;
         cfg_time_limit = TIME_LIMIT_RESET;
         cfg_step_limit = STEP_LIMIT_RESET;
         expected_points.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_TIME_LIMIT: cfg_time_limit = csr_data[TIME_W-1:0];
               CSR_STEP_LIMIT: cfg_step_limit = csr_data[COUNT_W-1:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got_status = rsp_tuser;
            got_time   = rsp_tdata[0 +: TIME_W];
            got_state  = rsp_tdata[TIME_W +: IDX_FIELD_W];
            got_count  = rsp_tdata[TIME_W + IDX_FIELD_W +: COUNT_W];
            if (expected_points.size() == 0) begin
               if (mismatch_total < 10)
                  $display("[%0t] result with no item waiting: status %0d time %h state %0d count %0d",
                           $time, got_status, got_time, got_state, got_count);
               mismatch_total++;
            end else begin
               want = expected_points.pop_front();
               checked_total++;
               if (got_status != want.status || got_time != want.sim_time ||
                   got_state != want.sim_state || got_count != want.jump_count) begin
                  if (mismatch_total < 10) begin
                     $display("[%0t] result %0d mismatch", $time, checked_total);
                     $display("   expected status %0d time %h state %0d count %0d",
                              want.status, want.sim_time, want.sim_state, want.jump_count);
                     $display("   actual   status %0d time %h state %0d count %0d",
                              got_status, got_time, got_state, got_count);
                  end
                  mismatch_total++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            want = advance_chain(req_tuser, req_tdata);
            if (want.status == ST_JUMPED) jump_total++;
            if (want.status inside {ST_TRAPPED, ST_TLIMIT, ST_SLIMIT}) end_total++;
            expected_points.insert(expected_points.size(), want);
         end
      end
      fail_count      <= mismatch_total;
      pending         <= expected_points.size();
      results_checked <= checked_total;
      jumps_seen      <= jump_total;
      ends_seen       <= end_total;
   end

endmodule

[verif/markov_jump_gillespie_step_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Jump stepper testbench
// Drives rate writes, run starts and jumps into the stepper with random
// stalls on both channels in the first four phases, sweeps the time and
// step limits through several settings including their extremes, and takes
// the verdict from the scoreboard that predicts every result.
// ----------------------------------------------------------------------------
module markov_jump_gillespie_step_core_tb;
   import mjgs_pkg::*;

   localparam int          PHASES      = 6;
   localparam int unsigned RUN_LIMIT   = 1_000_000;
   localparam int          TAIL_CYCLES = 64;
   localparam logic [REQ_TUSER_W-1:0] REQ_UNKNOWN = 2'd3;

   typedef struct packed {
      logic [IDX_FIELD_W-1:0] src_idx;
      logic [IDX_FIELD_W-1:0] dst_idx;
      logic [RATE_W-1:0]      rate;
      logic [IDX_FIELD_W-1:0] start_idx;
      logic [EXP_W-1:0]       expv;
      logic [UNIF_W-1:0]      unif;
   } req_item_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic [REQ_TUSER_W-1:0] req_tuser  = '0;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [RSP_TUSER_W-1:0] rsp_tuser;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_data   = '0;

   int unsigned send_idle_pct = 11;
   int unsigned recv_idle_pct = 55;
   int unsigned items_sent    = 0;
   int unsigned cycle_count   = 0;
   int          fail_count, pending, results_checked, jumps_seen, ends_seen;

   markov_jump_gillespie_step_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   mjgs_chain_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tuser       (req_tuser),
      .req_tdata       (req_tdata),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .rsp_tuser       (rsp_tuser),
      .rsp_tdata       (rsp_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .fail_count      (fail_count),
      .pending         (pending),
      .results_checked (results_checked),
      .jumps_seen      (jumps_seen),
      .ends_seen       (ends_seen)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      while (cycle_count < RUN_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("run limit of %0d cycles reached", RUN_LIMIT);
      $display("FAILED: results differ");
      $finish;
   end

   initial begin
      forever begin
         @(posedge clock);
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   function automatic req_item_type random_fields();
      req_item_type f;
      f.src_idx   = IDX_FIELD_W'($urandom());
      f.dst_idx   = IDX_FIELD_W'($urandom());
      f.rate      = RATE_W'($urandom());
      f.start_idx = IDX_FIELD_W'($urandom());
      f.expv      = $urandom();
      f.unif      = $urandom();
      return f;
   endfunction

   function automatic logic [RATE_W-1:0] pick_rate();
      case ($urandom_range(9))
         0:       return '0;
         1:       return RATE_W'($urandom_range(0, 24'hFF_FFFF));
         2:       return 24'hFF_FFFF;
         default: return RATE_W'($urandom_range(24'h00_4000, 24'h04_0000));
      endcase
   endfunction

   function automatic logic [EXP_W-1:0] pick_exp();
      case ($urandom_range(9))
         0:       return $urandom();
         1:       return '0;
         default: return $urandom_range(0, 32'h0300_0000);
      endcase
   endfunction

   task automatic send_item(input logic [REQ_TUSER_W-1:0] kind, input req_item_type f);
      logic [REQ_TDATA_W-1:0] d;
      d = '0;
      d[FROM_LSB +: IDX_FIELD_W]  = f.src_idx;
      d[TO_LSB +: IDX_FIELD_W]    = f.dst_idx;
      d[RATE_LSB +: RATE_W]       = f.rate;
      d[START_LSB +: IDX_FIELD_W] = f.start_idx;
      d[EXP_LSB +: EXP_W]         = f.expv;
      d[UNIF_LSB +: UNIF_W]       = f.unif;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= d;
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   task automatic write_rate(input logic [IDX_FIELD_W-1:0] src, input logic [IDX_FIELD_W-1:0] dst,
                             input logic [RATE_W-1:0] rate);
      req_item_type f;
      f = random_fields();
      f.src_idx = src;
      f.dst_idx = dst;
      f.rate    = rate;
      send_item(REQ_WRITE, f);
   endtask

   task automatic begin_run(input logic [IDX_FIELD_W-1:0] idx);
      req_item_type f;
      f = random_fields();
      f.start_idx = idx;
      send_item(REQ_START, f);
   endtask

   task automatic take_jump(input logic [EXP_W-1:0] expv, input logic [UNIF_W-1:0] unif);
      req_item_type f;
      f = random_fields();
      f.expv = expv;
      f.unif = unif;
      send_item(REQ_JUMP, f);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic random_run();
      int unsigned n_writes, n_jumps;
      n_writes = $urandom_range(0, 6);
      repeat (n_writes) write_rate(IDX_FIELD_W'($urandom_range(0, 3)),
                                   IDX_FIELD_W'($urandom_range(0, 3)), pick_rate());
      if ($urandom_range(9) == 0) send_item(REQ_UNKNOWN, random_fields());
      if ($urandom_range(9) == 0) take_jump(pick_exp(), $urandom());
      if ($urandom_range(24) == 0) wait_drained();
      begin_run(IDX_FIELD_W'($urandom_range(0, 3)));
      n_jumps = $urandom_range(1, 30);
      repeat (n_jumps) begin
         if ($urandom_range(29) == 0)
            write_rate(IDX_FIELD_W'($urandom_range(0, 3)),
                       IDX_FIELD_W'($urandom_range(0, 3)), pick_rate());
         take_jump(pick_exp(), $urandom());
      end
   endtask

   initial begin
      logic [TIME_W-1:0]  time_setting [PHASES];
      logic [COUNT_W-1:0] step_setting [PHASES];
      int unsigned        phase_items  [PHASES];
      int unsigned        phase_end;

      time_setting = '{32'h000A_0000, 32'hFFFF_FFFF, 32'h0000_0000,
                       32'h0002_0000, 32'h0040_0000, 32'h0000_0000};
      step_setting = '{16'd10000, 16'd20, 16'hFFFF, 16'd0, 16'd5, 16'd0};
      phase_items  = '{390, 390, 115, 115, 390, 390};
      time_setting[PHASES-1] = $urandom_range(32'h0001_0000, 32'h0020_0000);
      step_setting[PHASES-1] = COUNT_W'($urandom_range(1, 60));

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: idle cases, bad write, edge rates, trap, time limit
      take_jump(32'h0100_0000, 32'h0);
      send_item(REQ_UNKNOWN, random_fields());
      write_rate(2'd2, 2'd2, 24'h01_0000);
      write_rate(2'd0, 2'd1, 24'hFF_FFFF);
      write_rate(2'd0, 2'd3, 24'h00_0001);
      write_rate(2'd1, 2'd0, 24'h01_0000);
      write_rate(2'd1, 2'd2, 24'h01_0000);
      write_rate(2'd3, 2'd0, 24'h00_0001);
      begin_run(2'd0);
      take_jump(32'h0, 32'h0);
      take_jump(32'h0100_0000, 32'hFFFF_FFFF);
      take_jump(32'h0100_0000, 32'h8000_0000);
      take_jump(32'h0100_0000, 32'h8000_0000);
      begin_run(2'd1);
      take_jump(32'hFFFF_FFFF, 32'h0);
      begin_run(2'd3);
      take_jump(32'h0000_0001, 32'hFFFF_FFFF);
      take_jump(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      take_jump(32'h0, 32'h8000_0000);

      for (int p = 0; p < PHASES; p++) begin
         send_idle_pct = (p < 2) ? 11 : (p < 4) ? 55 : 0;
         recv_idle_pct = (p < 2) ? 55 : (p < 4) ? 11 : 0;
         wait_drained();
         write_reg(CSR_TIME_LIMIT, time_setting[p]);
         write_reg(CSR_STEP_LIMIT, CSR_DATA_W'(step_setting[p]));
         phase_end = items_sent + phase_items[p];
         while (items_sent < phase_end) random_run();
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Summary: %0d items over %0d limit settings, %0d results checked",
               items_sent, PHASES, results_checked);
      $display("Summary: %0d jumps taken, %0d runs ended by trap or limit",
               jumps_seen, ends_seen);
      if (fail_count == 0 && pending == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
